// File: design/fnvh_pkg.sv
`timescale 1ns / 1ps

package fnvh_pkg;

    // FNV-1a 64-bit offset basis
    localparam logic [63:0] HASH_BASIS = 64'hCBF29CE484222325;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Item kinds
    localparam logic [1:0] KIND_RAW   = 2'd0;
    localparam logic [1:0] KIND_FLOAT = 2'd1;
    localparam logic [1:0] KIND_BOOL  = 2'd2;

    // Single precision fields
    localparam logic [7:0]  FLOAT_EXP_ONES = 8'hFF;
    localparam logic [31:0] FLOAT_NEG_ZERO = 32'h80000000;

    // Classified word handed from front to back
    typedef struct packed {
        logic [63:0] word;     // word to absorb, already canonicalised
        logic        first;    // restart from basis, clear error
        logic        absorb;   // run the eight byte rounds
        logic        set_err;  // non-finite float seen
    } cmd_t;

    // One FNV-1a byte round: xor the byte in, multiply by the prime.
    // Prime is 2^40 + 0x1B3, so the product is a short sum of shifts.
    function automatic logic [63:0] fnvh_round(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

// File: design/fnvh_item_if.sv
`timescale 1ns / 1ps

interface fnvh_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] value;
    logic        first;

    modport source (output valid, output func, output value, output first, input ready);
    modport sink   (input valid, input func, input value, input first, output ready);
endinterface

// File: design/fnvh_result_if.sv
`timescale 1ns / 1ps

interface fnvh_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest;
    logic        error;

    modport source (output valid, output digest, output error, input ready);
    modport sink   (input valid, input digest, input error, output ready);
endinterface

// File: design/fnvh_front.sv
`timescale 1ns / 1ps

module fnvh_front
(
    fnvh_item_if.sink       item,
    input  logic            q_ready,
    output logic            q_push,
    output fnvh_pkg::cmd_t  q_cmd
);

    logic [31:0] fbits;
    logic        fnonfinite;

    assign fbits      = item.value[31:0];
    assign fnonfinite = (fbits[30:23] == fnvh_pkg::FLOAT_EXP_ONES);

    // handshake: take a word whenever the queue has room
    assign item.ready = q_ready;
    assign q_push     = item.valid && q_ready;

    // classify the word
    always_comb
    begin
        q_cmd.word    = item.value;
        q_cmd.first   = item.first;
        q_cmd.absorb  = 1'b0;
        q_cmd.set_err = 1'b0;
        case (item.func)
            fnvh_pkg::KIND_RAW:
            begin
                q_cmd.absorb = 1'b1;
            end
            fnvh_pkg::KIND_FLOAT:
            begin
                // negative zero folds to zero; upper half ignored
                q_cmd.word    = (fbits == fnvh_pkg::FLOAT_NEG_ZERO) ? 64'd0 : {32'd0, fbits};
                q_cmd.absorb  = !fnonfinite;
                q_cmd.set_err = fnonfinite;
            end
            fnvh_pkg::KIND_BOOL:
            begin
                q_cmd.word   = {63'd0, (item.value != 64'd0)};
                q_cmd.absorb = 1'b1;
            end
            default:
            begin
                // unused kind: report state only
                q_cmd.absorb = 1'b0;
            end
        endcase
    end

endmodule

// File: design/fnvh_queue.sv
`timescale 1ns / 1ps

module fnvh_queue
#(
    parameter int DEPTH = fnvh_pkg::QUEUE_DEPTH   // 2 or more
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fnvh_pkg::cmd_t  push_cmd,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output fnvh_pkg::cmd_t  pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fnvh_pkg::cmd_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CNT_W'(DEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with fill count");

endmodule

// File: design/fnvh_core.sv
`timescale 1ns / 1ps

module fnvh_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  fnvh_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    fnvh_result_if.source   result
);

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t      state_reg, state_next;
    logic [63:0] hash_reg, hash_next;
    logic        err_reg, err_next;
    logic [55:0] work_reg, work_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        ovalid_reg, ovalid_next;
    logic [63:0] odigest_reg, odigest_next;
    logic        oerr_reg, oerr_next;

    logic        out_free;
    logic [63:0] base_hash;
    logic        base_err;
    logic [63:0] round_val;

    assign out_free      = !ovalid_reg || result.ready;
    assign result.valid  = ovalid_reg;
    assign result.digest = odigest_reg;
    assign result.error  = oerr_reg;

    assign base_hash = q_cmd.first ? fnvh_pkg::HASH_BASIS : hash_reg;
    assign base_err  = q_cmd.first ? 1'b0 : err_reg;

    // one round per cycle, the last waiting on a free result register; byte 0 is done as the word is taken
    assign round_val = (state_reg == S_IDLE) ? fnvh_pkg::fnvh_round(base_hash, q_cmd.word[7:0])
                                             : fnvh_pkg::fnvh_round(hash_reg, work_reg[7:0]);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        err_next     = err_reg;
        work_next    = work_reg;
        cnt_next     = cnt_reg;
        ovalid_next  = ovalid_reg && !result.ready;
        odigest_next = odigest_reg;
        oerr_next    = oerr_reg;
        q_pop        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop    = 1'b1;
                    err_next = base_err || q_cmd.set_err;
                    if (q_cmd.absorb)
                    begin
                        hash_next  = round_val;
                        work_next  = q_cmd.word[63:8];
                        cnt_next   = 3'd1;
                        state_next = S_RUN;
                    end
                    else
                    begin
                        // nothing to absorb: report at once
                        hash_next    = base_hash;
                        ovalid_next  = 1'b1;
                        odigest_next = base_hash;
                        oerr_next    = base_err || q_cmd.set_err;
                    end
                end
            end
            S_RUN:
            begin
                if (cnt_reg != 3'd7)
                begin
                    hash_next = round_val;
                    work_next = {8'd0, work_reg[55:8]};
                    cnt_next  = cnt_reg + 3'd1;
                end
                else if (out_free)
                begin
                    // last byte goes straight to the output register
                    hash_next    = round_val;
                    ovalid_next  = 1'b1;
                    odigest_next = round_val;
                    oerr_next    = err_reg;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            hash_reg    <= fnvh_pkg::HASH_BASIS;
            err_reg     <= 1'b0;
            cnt_reg     <= 3'd0;
            ovalid_reg  <= 1'b0;
            work_reg    <= '0;
            odigest_reg <= '0;
            oerr_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            hash_reg    <= hash_next;
            err_reg     <= err_next;
            cnt_reg     <= cnt_next;
            ovalid_reg  <= ovalid_next;
            work_reg    <= work_next;
            odigest_reg <= odigest_next;
            oerr_reg    <= oerr_next;
        end
    end

    // checks
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (cnt_reg != 3'd0))
        else $error("round counter zero while running");

    a_pop_slot: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == S_IDLE && out_free))
        else $error("word taken with no room for its result");

    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN && cnt_reg == 3'd7 && out_free)
            |=> (ovalid_reg && state_reg == S_IDLE && odigest_reg == hash_reg))
        else $error("finished word not presented");

    a_hold_digest: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && state_reg == S_IDLE && !q_valid) |=> (hash_reg == $past(hash_reg)))
        else $error("hash moved with no word taken");

endmodule

// File: design/fnv1a_word_hasher.sv
`timescale 1ns / 1ps

// Running 64-bit FNV-1a digest over a stream of words. Each word on item is
// a raw 64-bit word (func 0), a single precision bit pattern (func 1, upper
// half ignored, negative zero taken as zero, infinity or NaN leaves the hash
// alone and sets the sticky error) or a boolean (func 2, absorbs 1 or 0);
// func 3 absorbs nothing. first restarts from the offset basis and clears
// error before the word is absorbed. Every word gives one result: the digest
// and error after it. Bytes go least significant first, one byte round per
// clock in a single xor-multiply unit, the last round waiting for a free
// result register; the back end takes no new word until every byte of an
// absorbed word is done. A QUEUE_DEPTH deep queue lets item accept words
// while the back end is busy or a result waits to be taken.
module fnv1a_word_hasher
#(
    parameter int QUEUE_DEPTH = fnvh_pkg::QUEUE_DEPTH   // 2 or more
)
(
    input  logic          clk,
    input  logic          rst_n,
    fnvh_item_if.sink     item,
    fnvh_result_if.source result
);

    logic           q_ready;
    logic           q_push;
    fnvh_pkg::cmd_t push_cmd;
    logic           q_valid;
    logic           q_pop;
    fnvh_pkg::cmd_t pop_cmd;

    // front: handshake and classification
    fnvh_front u_front
    (
        .item    (item),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    // decoupling queue
    fnvh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_cmd    (pop_cmd)
    );

    // back: byte rounds and result register
    fnvh_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (pop_cmd),
        .q_pop   (q_pop),
        .result  (result)
    );

endmodule

// File: test/fnv1a_word_hasher_test.sv
`timescale 1ns / 1ps

// One expected result: digest and sticky error after a word
typedef struct packed {
    logic [63:0] digest;
    logic        error;
} digest_entry_t;

// Tracks the running digest and checks each result against it
class fnv_digest_tracker;
    localparam logic [63:0] HASH_MULT = 64'd1099511628211;

    logic [63:0]   hash_now;
    logic          err_now;
    digest_entry_t owed[$];
    int            failures;

    function new();
        hash_now = fnvh_pkg::HASH_BASIS;
        err_now  = 1'b0;
        failures = 0;
    endfunction

    // Eight byte rounds, least significant byte first
    function void mix_word(logic [63:0] w);
        for (int k = 0; k < 8; k++)
            hash_now = (hash_now ^ {56'd0, w[8*k +: 8]}) * HASH_MULT;
    endfunction

    // Called when the block accepts a word
    function void note_word(logic [1:0] func, logic [63:0] value, logic first);
        logic [31:0]   bits;
        digest_entry_t e;
        if (first)
        begin
            hash_now = fnvh_pkg::HASH_BASIS;
            err_now  = 1'b0;
        end
        case (func)
            fnvh_pkg::KIND_RAW:
                mix_word(value);
            fnvh_pkg::KIND_FLOAT:
            begin
                bits = value[31:0];
                // infinity or NaN: hash untouched, error sticks
                if (bits[30:23] == fnvh_pkg::FLOAT_EXP_ONES)
                    err_now = 1'b1;
                else
                    mix_word({32'd0, (bits == fnvh_pkg::FLOAT_NEG_ZERO) ? 32'd0 : bits});
            end
            fnvh_pkg::KIND_BOOL:
                mix_word((value != 64'd0) ? 64'd1 : 64'd0);
            default:
                ;
        endcase
        e.digest = hash_now;
        e.error  = err_now;
        owed = {owed, e};
    endfunction

    // Called for each accepted result
    function void check_result(logic [63:0] digest, logic error);
        digest_entry_t e;
        if (owed.size() == 0)
        begin
            $error("unexpected result: digest %h error %b", digest, error);
            failures++;
            return;
        end
        e = owed.pop_front();
        if (digest !== e.digest)
        begin
            $error("digest: expected %h, got %h", e.digest, digest);
            failures++;
        end
        if (error !== e.error)
        begin
            $error("error: expected %b, got %b", e.error, error);
            failures++;
        end
    endfunction

    function int pending();
        return owed.size();
    endfunction
endclass

module fnv1a_word_hasher_test;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int         PHASE_WORDS = 208;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   stall_pct;
    int   words_sent;

    fnv_digest_tracker tracker = new();

    fnvh_item_if   item ();
    fnvh_result_if result ();

    fnv1a_word_hasher uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    // Clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Hard stop
    initial
    begin
        #2ms;
        $display("fnv1a_word_hasher_test: FAIL");
        $finish;
    end

    // Result side: check, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (result.valid && result.ready)
            tracker.check_result(result.digest, result.error);
        result.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Float pattern: mostly finite, some zeros, denormals and non-finites
    function automatic logic [63:0] random_float();
        logic [63:0] v;
        int          r;
        v = random_word();
        r = $urandom_range(99);
        if (r < 6)
            v[30:23] = fnvh_pkg::FLOAT_EXP_ONES;
        else if (r < 14)
            v[31:0] = fnvh_pkg::FLOAT_NEG_ZERO;
        else if (r < 20)
            v[31:0] = 32'd0;
        else if (r < 28)
            v[30:23] = 8'd0;
        else if (v[30:23] == fnvh_pkg::FLOAT_EXP_ONES)
            v[23] = 1'b0;
        return v;
    endfunction

    function automatic logic [63:0] random_bool();
        int r;
        r = $urandom_range(3);
        if (r == 0)
            return 64'd0;
        else if (r == 1)
            return 64'd1 << $urandom_range(63);
        return random_word();
    endfunction

    // Offer one word, with random idle cycles ahead of it
    task automatic send_word(logic [1:0] func, logic [63:0] value, logic first);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid <= 1'b1;
        item.func  <= func;
        item.value <= value;
        item.first <= first;
        do
            @(posedge clk);
        while (!item.ready);
        tracker.note_word(func, value, first);
        words_sent++;
    endtask

    // A restart followed by a run of words, with a little noise
    task automatic send_run();
        int          len;
        int          r;
        logic [1:0]  f;
        logic [63:0] v;
        logic        fst;
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++)
        begin
            fst = (k == 0) || ($urandom_range(99) < 3);
            r = $urandom_range(99);
            if (r < 4)
            begin
                f = KIND_UNUSED;
                v = random_word();
            end
            else if (r < 40)
            begin
                f = fnvh_pkg::KIND_RAW;
                v = ($urandom_range(19) == 0) ? {64{$urandom_range(1) == 1}} : random_word();
            end
            else if (r < 75)
            begin
                f = fnvh_pkg::KIND_FLOAT;
                v = random_float();
            end
            else
            begin
                f = fnvh_pkg::KIND_BOOL;
                v = random_bool();
            end
            send_word(f, v, fst);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        item.valid    = 1'b0;
        item.func     = fnvh_pkg::KIND_RAW;
        item.value    = 64'd0;
        item.first    = 1'b0;
        result.ready  = 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;
        words_sent    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, every kind and the float corner cases
        send_word(fnvh_pkg::KIND_RAW,   64'd0,                1'b0);
        send_word(fnvh_pkg::KIND_RAW,   64'hFFFFFFFFFFFFFFFF, 1'b0);
        send_word(fnvh_pkg::KIND_RAW,   64'h0123456789ABCDEF, 1'b1);
        send_word(fnvh_pkg::KIND_FLOAT, 64'h0000000000000000, 1'b1);
        send_word(fnvh_pkg::KIND_FLOAT, 64'h0000000080000000, 1'b1);   // negative zero
        send_word(fnvh_pkg::KIND_FLOAT, 64'hFFFFFFFF3F800000, 1'b0);   // upper half ignored
        send_word(fnvh_pkg::KIND_FLOAT, 64'h00000000007FFFFF, 1'b0);   // largest denormal
        send_word(fnvh_pkg::KIND_FLOAT, 64'h000000007F7FFFFF, 1'b0);   // largest finite
        send_word(fnvh_pkg::KIND_FLOAT, 64'h000000007F800000, 1'b0);   // +infinity
        send_word(fnvh_pkg::KIND_RAW,   64'hA5A5A5A5A5A5A5A5, 1'b0);   // absorbs with error set
        send_word(fnvh_pkg::KIND_FLOAT, 64'h00000000FF800000, 1'b1);   // -infinity after restart
        send_word(fnvh_pkg::KIND_FLOAT, 64'hFFFFFFFF7FC00001, 1'b0);   // NaN
        send_word(fnvh_pkg::KIND_FLOAT, 64'h00000000FFFFFFFF, 1'b0);   // NaN, all ones
        send_word(fnvh_pkg::KIND_BOOL,  64'd0,                1'b1);
        send_word(fnvh_pkg::KIND_BOOL,  64'd1,                1'b0);
        send_word(fnvh_pkg::KIND_BOOL,  64'hFFFFFFFFFFFFFFFF, 1'b0);
        send_word(fnvh_pkg::KIND_BOOL,  64'h8000000000000000, 1'b0);
        send_word(KIND_UNUSED,          64'hFFFFFFFFFFFFFFFF, 1'b0);
        send_word(fnvh_pkg::KIND_FLOAT, 64'h000000007F800001, 1'b0);
        send_word(KIND_UNUSED,          64'h0,                1'b1);   // restart, nothing absorbed
        send_word(KIND_UNUSED,          64'h5555555555555555, 1'b0);

        // Random runs under four idling patterns
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  stall_pct <= 0;  end
                1: begin send_idle_pct = 85; stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  stall_pct <= 85; end
                default: begin send_idle_pct = 28; stall_pct <= 28; end
            endcase
            while (words_sent < 21 + (p + 1) * PHASE_WORDS)
                send_run();
        end
        item.valid <= 1'b0;

        // Drain, then allow for stray results
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (tracker.failures == 0)
            $display("fnv1a_word_hasher_test: PASS");
        else
            $display("fnv1a_word_hasher_test: FAIL");
        $finish;
    end
endmodule
